// ----- sv/mlfq_pkg.sv -----
// Package: payload types, sizes and status codes for the feedback queue scheduler.
`timescale 1ns / 1ps
`default_nettype none
package mlfq_pkg;

    // job slots and priority levels; the word fields below are sized for these
    localparam int MAX_JOBS = 16;
    localparam int LEVELS   = 4;

    localparam logic [2:0] ST_IDLE     = 3'd0;
    localparam logic [2:0] ST_RAN      = 3'd1;
    localparam logic [2:0] ST_FINISHED = 3'd2;
    localparam logic [2:0] ST_ACCEPTED = 3'd3;
    localparam logic [2:0] ST_REJECTED = 3'd4;

    localparam logic REQ_ARRIVAL = 1'b0;
    localparam logic REQ_TICK    = 1'b1;

    localparam logic [1:0] CFG_L1_LIMIT = 2'd0;
    localparam logic [1:0] CFG_L2_LIMIT = 2'd1;
    localparam logic [1:0] CFG_L3_LIMIT = 2'd2;
    localparam logic [1:0] CFG_BOOST    = 2'd3;

    typedef struct packed {
        logic        req_type;
        logic [3:0]  job_id;
        logic [15:0] job_length;
    } in_word_t;

    typedef struct packed {
        logic [2:0]  status;
        logic [3:0]  ran_job;
        logic [1:0]  level_after;
        logic [31:0] start_time;
        logic [31:0] finish_time;
    } out_word_t;

endpackage
`default_nettype wire

// ----- sv/multilevel_feedback_queue_scheduler.sv -----
// Multilevel feedback queue scheduler: sequencer over slot and queue memories.
//
// Usage: words enter on in_word (in_valid / in_stall); each produces exactly
// one result word on out_word (out_valid / out_stall). An arrival word places
// a job in its slot at the tail of the top level; a tick word runs one unit
// of the head job of the highest non-empty level. Config registers are
// written over cfg_valid / cfg_ready / cfg_index / cfg_data while idle.
// Steps: a rejected arrival registers its result in the idle state, an
// accepted arrival passes S_ARR, a tick passes S_PICK and, if a job waits,
// S_QREAD, S_SREAD, S_WAIT, S_EXEC, then S_DONE. A tick that boosts first
// scans, then per job moved off the lower levels pops, moves, reads and
// writes the slot, and rescans; the registered memory reads set these steps.
// Words are taken one at a time; in_stall stays high while a result waits
// under out_stall, and the result register holds its word meanwhile.
// Reset clears time, boost counter, slot flags and queue pointers; the
// slot and queue memories hold no reset value and need no clearing pass.
`timescale 1ns / 1ps
`default_nettype none
module multilevel_feedback_queue_scheduler (
    input  wire                       clk,
    input  wire                       rst_n,
    input  wire                       in_valid,
    output logic                      in_stall,
    input  mlfq_pkg::in_word_t        in_word,
    output logic                      out_valid,
    input  wire                       out_stall,
    output mlfq_pkg::out_word_t       out_word,
    input  wire                       cfg_valid,
    output logic                      cfg_ready,
    input  wire  [1:0]                cfg_index,
    input  wire  [15:0]               cfg_data
);

    localparam int MAX_JOBS = mlfq_pkg::MAX_JOBS;
    localparam int LEVELS   = mlfq_pkg::LEVELS;
    localparam int JW = (MAX_JOBS > 1) ? $clog2(MAX_JOBS) : 1;
    localparam int LW = (LEVELS > 1) ? $clog2(LEVELS) : 1;
    localparam int CW = $clog2(MAX_JOBS + 1);
    localparam int QA = LW + JW;

    typedef enum logic [3:0] {
        S_IDLE, S_ARR, S_BSCAN, S_BREAD, S_BMOVE, S_BFIX, S_BCLR, S_PICK,
        S_QREAD, S_SREAD, S_WAIT, S_EXEC, S_DONE
    } state_t;

    // slot memory row
    typedef struct packed {
        logic [15:0] remaining;
        logic [8:0]  used;
        logic [31:0] start;
    } slot_t;

    state_t state_reg;
    logic [7:0]  lim1_reg, lim2_reg, lim3_reg;
    logic [15:0] period_reg;
    logic [31:0] now_reg;
    logic [15:0] bcnt_reg;
    logic        seen_reg;
    logic [MAX_JOBS-1:0] busy_reg, started_reg;
    logic [JW-1:0] head_reg [LEVELS];
    logic [CW-1:0] count_reg [LEVELS];
    mlfq_pkg::in_word_t  req_reg;
    mlfq_pkg::out_word_t out_reg;
    logic      out_valid_reg;
    logic [LW-1:0] lvl_reg;
    logic [JW-1:0] job_reg;

    // memories
    slot_t       slot_mem [MAX_JOBS];
    logic [JW-1:0] queue_mem [LEVELS*MAX_JOBS];
    slot_t       slot_rd;
    logic [JW-1:0] queue_rd;
    logic        slot_we, queue_we;
    logic [JW-1:0] slot_wa, slot_ra;
    slot_t       slot_wd;
    logic [QA-1:0] queue_wa, queue_ra;
    logic [JW-1:0] queue_wd;

    always_ff @(posedge clk)
    begin
        if (slot_we)
        begin
            slot_mem[slot_wa] <= slot_wd;
        end
        slot_rd <= slot_mem[slot_ra];
        if (queue_we)
        begin
            queue_mem[queue_wa] <= queue_wd;
        end
        queue_rd <= queue_mem[queue_ra];
    end

    function automatic logic [QA-1:0] qaddr(input logic [LW-1:0] l, input logic [JW-1:0] p);
        qaddr = {l, p};
    endfunction

    function automatic logic [JW-1:0] wrap_add(input logic [JW-1:0] a, input logic [CW-1:0] b);
        logic [CW:0] s;
        s = {{(CW+1-JW){1'b0}}, a} + {1'b0, b};
        if (s >= (CW+1)'(MAX_JOBS))
        begin
            s = s - (CW+1)'(MAX_JOBS);
        end
        wrap_add = s[JW-1:0];
    endfunction

    // highest-priority non-empty level overall (top_lvl) and below level 0 (low_lvl)
    logic          any_low, any_all;
    logic [LW-1:0] low_lvl, top_lvl;
    always_comb
    begin
        any_low = 1'b0;
        low_lvl = '0;
        any_all = 1'b0;
        top_lvl = '0;
        for (int i = LEVELS - 1; i >= 0; i--)
        begin
            if (count_reg[i] != '0)
            begin
                any_all = 1'b1;
                top_lvl = LW'(i);
                if (i != 0)
                begin
                    any_low = 1'b1;
                    low_lvl = LW'(i);
                end
            end
        end
    end

    logic in_acc;
    logic in_reject;
    logic out_load;
    assign in_stall  = (state_reg != S_IDLE) || (out_valid_reg && out_stall);
    assign in_acc    = in_valid && !in_stall;
    assign cfg_ready = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;
    assign out_word  = out_reg;

    // arrival check: zero length, slot out of range or slot busy
    assign in_reject = (in_word.job_length == '0)
        || (32'(in_word.job_id) >= 32'(MAX_JOBS))
        || busy_reg[in_word.job_id[JW-1:0]];

    // states that register a result word
    always_comb
    begin
        out_load = ((state_reg == S_IDLE) && in_acc
                    && (in_word.req_type == mlfq_pkg::REQ_ARRIVAL) && in_reject)
            || (state_reg == S_ARR)
            || ((state_reg == S_PICK) && !any_all)
            || (state_reg == S_EXEC);
    end

    // execute step values
    logic [15:0] rem_dec;
    logic [8:0]  used_inc;
    logic [7:0]  lim_sel;
    logic [31:0] st_val;
    logic        is_start;
    always_comb
    begin
        is_start = !started_reg[job_reg];
        rem_dec  = slot_rd.remaining - 16'd1;
        used_inc = slot_rd.used + 9'd1;
        st_val   = is_start ? now_reg : slot_rd.start;
        case (lvl_reg)
            LW'(0):  lim_sel = lim1_reg;
            LW'(1):  lim_sel = lim2_reg;
            default: lim_sel = lim3_reg;
        endcase
    end

    logic          demote;
    logic [LW-1:0] new_lvl;
    always_comb
    begin
        demote  = (lvl_reg != LW'(LEVELS - 1)) && (used_inc > {1'b0, lim_sel});
        new_lvl = demote ? lvl_reg + LW'(1) : lvl_reg;
    end

    // queue tail write address for the requeue in S_EXEC uses new level
    logic [QA-1:0] exec_wa;
    assign exec_wa = qaddr(new_lvl, wrap_add(head_reg[new_lvl], count_reg[new_lvl]));

    // memory port control
    always_comb
    begin
        slot_we  = 1'b0;
        slot_wa  = job_reg;
        slot_wd  = slot_rd;
        slot_ra  = job_reg;
        queue_we = 1'b0;
        queue_wa = qaddr('0, wrap_add(head_reg[0], count_reg[0]));
        queue_wd = job_reg;
        queue_ra = qaddr(lvl_reg, head_reg[lvl_reg]);
        case (state_reg)
            S_ARR:
            begin
                slot_we  = 1'b1;
                slot_wa  = req_reg.job_id[JW-1:0];
                slot_wd  = '{remaining: req_reg.job_length, used: 9'd0, start: 32'd0};
                queue_we = 1'b1;
                queue_wd = req_reg.job_id[JW-1:0];
            end
            S_BMOVE:
            begin
                queue_we = 1'b1;
                queue_wd = queue_rd;
            end
            S_BCLR:
            begin
                // boosted job: usage cleared, rest of the row kept
                slot_we      = 1'b1;
                slot_wd.used = 9'd0;
            end
            S_EXEC:
            begin
                slot_we = 1'b1;
                slot_wd.start = st_val;
                slot_wd.remaining = rem_dec;
                if (lvl_reg != LW'(LEVELS - 1))
                begin
                    slot_wd.used = (used_inc > {1'b0, lim_sel}) ? 9'd0 : used_inc;
                end
                queue_wa = exec_wa;
                if (rem_dec != '0)
                begin
                    queue_we = 1'b1;
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            lim1_reg      <= 8'd10;
            lim2_reg      <= 8'd20;
            lim3_reg      <= 8'd40;
            period_reg    <= 16'd50;
            now_reg       <= '0;
            bcnt_reg      <= '0;
            seen_reg      <= 1'b0;
            busy_reg      <= '0;
            started_reg   <= '0;
            req_reg       <= '0;
            out_reg       <= '0;
            out_valid_reg <= 1'b0;
            lvl_reg       <= '0;
            job_reg       <= '0;
            for (int i = 0; i < LEVELS; i++)
            begin
                head_reg[i]  <= '0;
                count_reg[i] <= '0;
            end
        end
        else
        begin
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_valid_reg && !out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    mlfq_pkg::CFG_L1_LIMIT: lim1_reg   <= cfg_data[7:0];
                    mlfq_pkg::CFG_L2_LIMIT: lim2_reg   <= cfg_data[7:0];
                    mlfq_pkg::CFG_L3_LIMIT: lim3_reg   <= cfg_data[7:0];
                    mlfq_pkg::CFG_BOOST:    period_reg <= cfg_data;
                    default:
                    begin
                    end
                endcase
            end
            case (state_reg)
                S_IDLE:
                begin
                    if (in_acc)
                    begin
                        req_reg <= in_word;
                        if (in_word.req_type == mlfq_pkg::REQ_ARRIVAL)
                        begin
                            if (in_reject)
                            begin
                                out_reg <= '{status: mlfq_pkg::ST_REJECTED,
                                    ran_job: in_word.job_id, level_after: 2'd0,
                                    start_time: 32'd0, finish_time: 32'd0};
                            end
                            else
                            begin
                                state_reg <= S_ARR;
                            end
                        end
                        else if (seen_reg && bcnt_reg == '0)
                        begin
                            state_reg <= S_BSCAN;
                        end
                        else
                        begin
                            state_reg <= S_PICK;
                        end
                    end
                end
                S_ARR:
                begin
                    busy_reg[req_reg.job_id[JW-1:0]]    <= 1'b1;
                    started_reg[req_reg.job_id[JW-1:0]] <= 1'b0;
                    count_reg[0] <= count_reg[0] + CW'(1);
                    seen_reg     <= 1'b1;
                    out_reg <= '{status: mlfq_pkg::ST_ACCEPTED,
                        ran_job: req_reg.job_id, level_after: 2'd0,
                        start_time: 32'd0, finish_time: 32'd0};
                    state_reg     <= S_IDLE;
                end
                S_BSCAN:
                begin
                    if (any_low)
                    begin
                        lvl_reg   <= low_lvl;
                        state_reg <= S_BREAD;
                    end
                    else
                    begin
                        state_reg <= S_PICK;
                    end
                end
                S_BREAD:
                begin
                    // queue_rd valid next cycle; pop the head now
                    head_reg[lvl_reg]  <= wrap_add(head_reg[lvl_reg], CW'(1));
                    count_reg[lvl_reg] <= count_reg[lvl_reg] - CW'(1);
                    state_reg <= S_BMOVE;
                end
                S_BMOVE:
                begin
                    count_reg[0] <= count_reg[0] + CW'(1);
                    state_reg    <= S_BFIX;
                    job_reg      <= queue_rd;
                end
                S_BFIX:
                begin
                    // slot row of the moved job is read here
                    state_reg <= S_BCLR;
                end
                S_BCLR:
                begin
                    state_reg <= S_BSCAN;
                end
                S_PICK:
                begin
                    if (any_all)
                    begin
                        lvl_reg   <= top_lvl;
                        state_reg <= S_QREAD;
                    end
                    else
                    begin
                        now_reg <= now_reg + 32'd1;
                        out_reg <= '{status: mlfq_pkg::ST_IDLE, ran_job: 4'd0,
                            level_after: 2'd0, start_time: 32'd0, finish_time: 32'd0};
                        state_reg     <= S_DONE;
                    end
                end
                S_QREAD:
                begin
                    head_reg[lvl_reg]  <= wrap_add(head_reg[lvl_reg], CW'(1));
                    count_reg[lvl_reg] <= count_reg[lvl_reg] - CW'(1);
                    state_reg <= S_SREAD;
                end
                S_SREAD:
                begin
                    job_reg   <= queue_rd;
                    state_reg <= S_WAIT;
                end
                S_WAIT:
                begin
                    state_reg <= S_EXEC;
                end
                S_EXEC:
                begin
                    started_reg[job_reg] <= 1'b1;
                    now_reg <= now_reg + 32'd1;
                    if (rem_dec != '0)
                    begin
                        count_reg[new_lvl] <= count_reg[new_lvl] + CW'(1);
                        out_reg <= '{status: mlfq_pkg::ST_RAN, ran_job: 4'(job_reg),
                            level_after: 2'(new_lvl), start_time: st_val,
                            finish_time: 32'd0};
                    end
                    else
                    begin
                        busy_reg[job_reg] <= 1'b0;
                        out_reg <= '{status: mlfq_pkg::ST_FINISHED, ran_job: 4'(job_reg),
                            level_after: 2'(lvl_reg), start_time: st_val,
                            finish_time: now_reg + 32'd1};
                    end
                    state_reg     <= S_DONE;
                end
                S_DONE:
                begin
                    if (seen_reg)
                    begin
                        if (bcnt_reg + 16'd1 >= period_reg)
                        begin
                            bcnt_reg <= '0;
                        end
                        else
                        begin
                            bcnt_reg <= bcnt_reg + 16'd1;
                        end
                    end
                    state_reg <= S_IDLE;
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

`ifndef SYNTHESIS
    // a result is never overwritten while the receiver stalls it
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(out_word))
        else $error("result dropped under stall");
    // an accepted word either starts a sequence or leaves a result
    assert property (@(posedge clk) disable iff (!rst_n)
        in_acc |=> (state_reg != S_IDLE) || out_valid)
        else $error("accepted word lost");
    // top-level queue fill never exceeds the slot count
    assert property (@(posedge clk) disable iff (!rst_n)
        count_reg[0] <= CW'(MAX_JOBS))
        else $error("top queue overflow");
    // config is taken only while idle
    assert property (@(posedge clk) disable iff (!rst_n)
        cfg_ready |-> state_reg == S_IDLE)
        else $error("config while busy");
`endif

endmodule
`default_nettype wire

// ----- tb/multilevel_feedback_queue_scheduler_tb.sv -----
// Testbench for the feedback queue scheduler: directed table, random traffic, scoreboard.
`timescale 1ns / 1ps
module multilevel_feedback_queue_scheduler_tb;

    localparam int NJOBS = 16;
    localparam int NLVL = 4;
    localparam int WATCHDOG_LIMIT = 20000;
    localparam int DRAIN_CYCLES = 60;
    localparam int EXP_DEPTH = 64;
    localparam int MAX_ROWS = 32;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic in_valid = 1'b0;
    logic in_stall;
    mlfq_pkg::in_word_t in_word = '0;
    logic out_valid;
    logic out_stall = 1'b0;
    mlfq_pkg::out_word_t out_word;
    logic cfg_valid = 1'b0;
    logic cfg_ready;
    logic [1:0] cfg_index = '0;
    logic [15:0] cfg_data = '0;

    multilevel_feedback_queue_scheduler dut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall), .in_word(in_word),
        .out_valid(out_valid), .out_stall(out_stall), .out_word(out_word),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // Scheduler shadow state
    logic [7:0] lim [3];
    logic [15:0] boost_per;
    logic [31:0] clock_now;
    logic [15:0] boost_cnt;
    logic started_any;
    logic busy [NJOBS];
    logic began [NJOBS];
    logic [15:0] left [NJOBS];
    logic [8:0] used [NJOBS];
    logic [31:0] run_start [NJOBS];
    int sched_q [NLVL][NJOBS];
    int sq_head [NLVL];
    int sq_cnt [NLVL];

    // Expected results in order
    mlfq_pkg::out_word_t exp_fifo [EXP_DEPTH];
    int exp_wr = 0;
    int exp_rd = 0;
    int mismatches = 0;
    int idle_cycles = 0;
    logic timed_out = 1'b0;

    typedef struct {
        mlfq_pkg::in_word_t w;
        logic fixed;
        mlfq_pkg::out_word_t r;
    } row_t;

    row_t dir_rows [MAX_ROWS];
    int n_rows = 0;

    function automatic void q_put(int l, int j);
        sched_q[l][(sq_head[l] + sq_cnt[l]) % NJOBS] = j;
        sq_cnt[l]++;
    endfunction

    function automatic int q_take(int l);
        int j;
        j = sched_q[l][sq_head[l]];
        sq_head[l] = (sq_head[l] + 1) % NJOBS;
        sq_cnt[l]--;
        return j;
    endfunction

    function automatic mlfq_pkg::out_word_t schedule_step(mlfq_pkg::in_word_t w);
        mlfq_pkg::out_word_t r;
        int lv;
        int j;
        r = '0;
        if (w.req_type == mlfq_pkg::REQ_ARRIVAL)
        begin
            r.ran_job = w.job_id;
            if (w.job_length == '0 || busy[w.job_id])
            begin
                r.status = mlfq_pkg::ST_REJECTED;
            end
            else
            begin
                busy[w.job_id] = 1'b1;
                began[w.job_id] = 1'b0;
                left[w.job_id] = w.job_length;
                used[w.job_id] = '0;
                run_start[w.job_id] = '0;
                q_put(0, int'(w.job_id));
                started_any = 1'b1;
                r.status = mlfq_pkg::ST_ACCEPTED;
            end
        end
        else
        begin
            // boost: lower levels to top, in level then queue order
            if (started_any && boost_cnt == '0)
            begin
                for (int l = 1; l < NLVL; l++)
                begin
                    while (sq_cnt[l] != 0)
                    begin
                        j = q_take(l);
                        used[j] = '0;
                        q_put(0, j);
                    end
                end
            end
            lv = 0;
            while (lv < NLVL && sq_cnt[lv] == 0) lv++;
            if (lv < NLVL)
            begin
                j = q_take(lv);
                r.ran_job = 4'(j);
                if (!began[j])
                begin
                    began[j] = 1'b1;
                    run_start[j] = clock_now;
                end
                left[j] = left[j] - 16'd1;
                clock_now = clock_now + 32'd1;
                r.start_time = run_start[j];
                if (left[j] != '0)
                begin
                    r.status = mlfq_pkg::ST_RAN;
                    if (lv + 1 < NLVL)
                    begin
                        used[j] = used[j] + 9'd1;
                        if (used[j] > {1'b0, lim[lv > 2 ? 2 : lv]})
                        begin
                            used[j] = '0;
                            lv++;
                        end
                    end
                    q_put(lv, j);
                end
                else
                begin
                    r.status = mlfq_pkg::ST_FINISHED;
                    r.finish_time = clock_now;
                    busy[j] = 1'b0;
                end
                r.level_after = 2'(lv);
            end
            else
            begin
                clock_now = clock_now + 32'd1;
            end
            if (started_any)
            begin
                boost_cnt = boost_cnt + 16'd1;
                if (boost_cnt >= boost_per) boost_cnt = '0;
            end
        end
        return r;
    endfunction

    // Config write while idle
    task automatic write_reg(logic [1:0] idx, logic [15:0] val);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        case (idx)
            mlfq_pkg::CFG_L1_LIMIT: lim[0] = val[7:0];
            mlfq_pkg::CFG_L2_LIMIT: lim[1] = val[7:0];
            mlfq_pkg::CFG_L3_LIMIT: lim[2] = val[7:0];
            mlfq_pkg::CFG_BOOST: boost_per = (val == '0) ? 16'd1 : val;
            default:
            begin
            end
        endcase
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // Send one word; optionally check a typed-in result against the predictor
    task automatic send_word(mlfq_pkg::in_word_t w, logic has_fixed,
                             mlfq_pkg::out_word_t fixed);
        mlfq_pkg::out_word_t p;
        int gap;
        gap = $urandom_range(0, 8);
        if ($urandom_range(0, 3) == 0) gap = 0;
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid <= 1'b1;
        in_word <= w;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        p = schedule_step(w);
        if (has_fixed && p !== fixed)
        begin
            mismatches++;
            if (mismatches <= 10)
                $display("table row disagrees with predictor: %h vs %h", fixed, p);
        end
        exp_fifo[exp_wr % EXP_DEPTH] = p;
        exp_wr++;
        @(negedge clk);
    endtask

    // Pause the sender until every expected result has come
    task automatic wait_drained();
        in_valid <= 1'b0;
        while (exp_wr != exp_rd) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    function automatic mlfq_pkg::in_word_t mk(logic t, logic [3:0] id, logic [15:0] len);
        mlfq_pkg::in_word_t w;
        w.req_type = t;
        w.job_id = id;
        w.job_length = len;
        return w;
    endfunction

    function automatic mlfq_pkg::out_word_t res(logic [2:0] s, logic [3:0] j, logic [1:0] l,
                                                logic [31:0] st, logic [31:0] fin);
        mlfq_pkg::out_word_t r;
        r.status = s;
        r.ran_job = j;
        r.level_after = l;
        r.start_time = st;
        r.finish_time = fin;
        return r;
    endfunction

    function automatic void add_row(mlfq_pkg::in_word_t w, logic fx, mlfq_pkg::out_word_t r);
        dir_rows[n_rows] = '{w, fx, r};
        n_rows++;
    endfunction

    // Result checker
    always @(posedge clk)
    begin
        mlfq_pkg::out_word_t e;
        if (out_valid && !out_stall)
        begin
            if (exp_wr == exp_rd)
            begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected result %h", out_word);
            end
            else
            begin
                e = exp_fifo[exp_rd % EXP_DEPTH];
                exp_rd++;
                if (out_word !== e)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display({"mismatch: exp st=%0d job=%0d lvl=%0d s=%0d f=%0d,",
                                  " got st=%0d job=%0d lvl=%0d s=%0d f=%0d"},
                                 e.status, e.ran_job, e.level_after, e.start_time,
                                 e.finish_time, out_word.status, out_word.ran_job,
                                 out_word.level_after, out_word.start_time,
                                 out_word.finish_time);
                end
            end
        end
    end

    // Output stall: a random wait after each taken result
    int stall_left = 0;
    always @(negedge clk)
    begin
        if (stall_left > 0)
        begin
            stall_left <= stall_left - 1;
            out_stall <= 1'b1;
        end
        else if (out_valid && !out_stall)
        begin
            stall_left <= $urandom_range(0, 8);
            out_stall <= 1'b0;
        end
        else
        begin
            out_stall <= 1'b0;
        end
    end

    // Watchdog on cycles without any accepted word, taken result or config write
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && !in_stall) || (out_valid && !out_stall)
                || (cfg_valid && cfg_ready))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= WATCHDOG_LIMIT) timed_out <= 1'b1;
        end
    end

    // Random mix: about 30% arrivals, mostly short jobs, and ticks otherwise
    task automatic random_phase(int n);
        int k;
        logic [15:0] len;
        k = 0;
        while (k < n)
        begin
            if ($urandom_range(0, 99) < 30)
            begin
                case ($urandom_range(0, 9))
                    0: len = 16'd0;
                    1: len = 16'($urandom_range(0, 65535));
                    2: len = 16'hFFFF;
                    default: len = 16'($urandom_range(1, 40));
                endcase
                send_word(mk(mlfq_pkg::REQ_ARRIVAL, 4'($urandom_range(0, 15)), len),
                          1'b0, '0);
            end
            else
            begin
                send_word(mk(mlfq_pkg::REQ_TICK, 4'($urandom_range(0, 15)),
                             16'($urandom)), 1'b0, '0);
            end
            k++;
        end
    endtask

    initial
    begin
        lim[0] = 8'd10;
        lim[1] = 8'd20;
        lim[2] = 8'd40;
        boost_per = 16'd50;
        clock_now = '0;
        boost_cnt = '0;
        started_any = 1'b0;
        for (int i = 0; i < NJOBS; i++)
        begin
            busy[i] = 1'b0;
            began[i] = 1'b0;
        end
        for (int i = 0; i < NLVL; i++)
        begin
            sq_head[i] = 0;
            sq_cnt[i] = 0;
        end
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Directed table: idle before arrival, rejects, extremes, finish
        add_row(mk(mlfq_pkg::REQ_TICK, 4'hF, 16'hFFFF), 1'b1,
                res(mlfq_pkg::ST_IDLE, 4'd0, 2'd0, 32'd0, 32'd0));
        add_row(mk(mlfq_pkg::REQ_ARRIVAL, 4'h3, 16'h0), 1'b1,
                res(mlfq_pkg::ST_REJECTED, 4'd3, 2'd0, 32'd0, 32'd0));
        add_row(mk(mlfq_pkg::REQ_ARRIVAL, 4'h0, 16'h1), 1'b1,
                res(mlfq_pkg::ST_ACCEPTED, 4'd0, 2'd0, 32'd0, 32'd0));
        add_row(mk(mlfq_pkg::REQ_ARRIVAL, 4'h0, 16'h5), 1'b1,
                res(mlfq_pkg::ST_REJECTED, 4'd0, 2'd0, 32'd0, 32'd0));
        add_row(mk(mlfq_pkg::REQ_ARRIVAL, 4'hF, 16'hFFFF), 1'b1,
                res(mlfq_pkg::ST_ACCEPTED, 4'd15, 2'd0, 32'd0, 32'd0));
        add_row(mk(mlfq_pkg::REQ_TICK, 4'h0, 16'h0), 1'b1,
                res(mlfq_pkg::ST_FINISHED, 4'd0, 2'd0, 32'd1, 32'd2));
        add_row(mk(mlfq_pkg::REQ_TICK, 4'h0, 16'h0), 1'b1,
                res(mlfq_pkg::ST_RAN, 4'd15, 2'd0, 32'd2, 32'd0));
        add_row(mk(mlfq_pkg::REQ_ARRIVAL, 4'hA, 16'h3), 1'b0, '0);
        add_row(mk(mlfq_pkg::REQ_ARRIVAL, 4'h5, 16'h2A), 1'b0, '0);
        for (int i = 0; i < 16; i++)
            add_row(mk(mlfq_pkg::REQ_TICK, 4'h0, 16'h0), 1'b0, '0);
        for (int i = 0; i < n_rows; i++)
            send_word(dir_rows[i].w, dir_rows[i].fixed, dir_rows[i].r);
        wait_drained();

        // Extremes: zero limits, boost every tick
        write_reg(mlfq_pkg::CFG_L1_LIMIT, 16'd0);
        write_reg(mlfq_pkg::CFG_L2_LIMIT, 16'd0);
        write_reg(mlfq_pkg::CFG_L3_LIMIT, 16'd0);
        write_reg(mlfq_pkg::CFG_BOOST, 16'd1);
        random_phase(300);
        wait_drained();

        // Max limits, max period
        write_reg(mlfq_pkg::CFG_L1_LIMIT, 16'd255);
        write_reg(mlfq_pkg::CFG_L2_LIMIT, 16'd255);
        write_reg(mlfq_pkg::CFG_L3_LIMIT, 16'd255);
        write_reg(mlfq_pkg::CFG_BOOST, 16'hFFFF);
        random_phase(300);
        wait_drained();

        // Small limits so jobs reach the bottom level; moderate boosts
        write_reg(mlfq_pkg::CFG_L1_LIMIT, 16'd1);
        write_reg(mlfq_pkg::CFG_L2_LIMIT, 16'd2);
        write_reg(mlfq_pkg::CFG_L3_LIMIT, 16'd3);
        write_reg(mlfq_pkg::CFG_BOOST, 16'd37);
        random_phase(500);
        wait_drained();

        // Random settings
        write_reg(mlfq_pkg::CFG_L1_LIMIT, 16'($urandom_range(0, 255)));
        write_reg(mlfq_pkg::CFG_L2_LIMIT, 16'($urandom_range(0, 255)));
        write_reg(mlfq_pkg::CFG_L3_LIMIT, 16'($urandom_range(0, 255)));
        write_reg(mlfq_pkg::CFG_BOOST, 16'($urandom_range(1, 100)));
        random_phase(600);
        wait_drained();
        if (mismatches == 0 && exp_wr == exp_rd)
            $display("PASS multilevel_feedback_queue_scheduler");
        else
            $display("FAIL multilevel_feedback_queue_scheduler");
        $finish;
    end

    initial
    begin
        wait (timed_out);
        $display("FAIL multilevel_feedback_queue_scheduler");
        $finish;
    end
endmodule

// ----- filelist.f -----
sv/mlfq_pkg.sv
sv/multilevel_feedback_queue_scheduler.sv
tb/multilevel_feedback_queue_scheduler_tb.sv
